@@ sv/kst_pkg.sv @@
// ----------------------------------------------------------------------------
// kst_pkg
// Shared types, constants and helpers for the spanning tree block.
// ----------------------------------------------------------------------------
package kst_pkg;

  localparam int WEIGHT_BITS   = 16;
  localparam int NODE_BITS     = 6;
  localparam int NODES_DEF     = 32;
  localparam int MAX_EDGES_DEF = 64;
  localparam int CFG_IDX_BITS  = 4;
  localparam int CFG_DATA_BITS = 6;
  localparam int QUEUE_DEPTH   = 4;

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_NODE_COUNT = 4'd0,
    REG_MAXIMIZE   = 4'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [NODE_BITS-1:0]          edge_u;
    logic [NODE_BITS-1:0]          edge_v;
    logic signed [WEIGHT_BITS-1:0] edge_weight;
    logic                          edge_last;
  } edge_in_t;

  typedef struct packed {
    logic [NODE_BITS-1:0]          tree_u;
    logic [NODE_BITS-1:0]          tree_v;
    logic signed [WEIGHT_BITS-1:0] tree_weight;
    logic                          edge_valid;
    logic                          result_last;
    logic                          edges_dropped;
  } tree_out_t;

  // one stored edge
  typedef struct packed {
    logic [NODE_BITS-1:0]          u;
    logic [NODE_BITS-1:0]          v;
    logic signed [WEIGHT_BITS-1:0] w;
  } edge_rec_t;

  // classified item between front and back
  typedef struct packed {
    logic      ok;
    logic      last;
    edge_rec_t e;
  } q_item_t;

  // settings handed from front to back
  typedef struct packed {
    logic [NODE_BITS-1:0] eff_nodes;
    logic                 maximize;
  } cfg_t;

  typedef enum logic [3:0] {
    B_LOAD,
    B_CLEAR,
    B_SCAN,
    B_FINDU_REQ,
    B_FINDU_CHK,
    B_FINDV_REQ,
    B_FINDV_CHK,
    B_LINK,
    B_BUMP,
    B_EMIT,
    B_FINAL
  } back_state_t;

  // unsigned order key of a weight, ascending in processing order
  function automatic logic [WEIGHT_BITS-1:0] weight_key(
    input logic signed [WEIGHT_BITS-1:0] w,
    input logic                          maximize
  );
    logic [WEIGHT_BITS-1:0] k;
    k = {~w[WEIGHT_BITS-1], w[WEIGHT_BITS-2:0]};
    return maximize ? ~k : k;
  endfunction

endpackage

@@ sv/kst_fifo.sv @@
// ----------------------------------------------------------------------------
// kst_fifo
// Small first-word-fall-through queue of register entries.
// ----------------------------------------------------------------------------
module kst_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wp;
  logic [AW-1:0]    rp;
  logic [AW:0]      cnt;
  logic             do_wr;
  logic             do_rd;

  assign full  = (cnt == (AW+1)'(DEPTH));
  assign empty = (cnt == '0);
  assign rdata = mem[rp];
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;

  // entry storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wp] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_wr) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (do_rd) begin
        rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      cnt <= cnt + (AW+1)'(do_wr) - (AW+1)'(do_rd);
    end
  end

endmodule

@@ sv/kst_front.sv @@
// ----------------------------------------------------------------------------
// kst_front
// Configuration registers and endpoint check of incoming edge beats.
// ----------------------------------------------------------------------------
module kst_front import kst_pkg::*; #(
  parameter int NODES = NODES_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     push,
  input  edge_in_t                 edge_in,
  output logic                     q_push,
  output q_item_t                  q_item,
  input  logic                     q_full,
  output cfg_t                     cfg
);
  logic [NODE_BITS-1:0] node_count;
  logic                 maximize;
  logic [NODE_BITS-1:0] eff;

  assign cfg_ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_BITS'(32);
      maximize   <= 1'b0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_NODE_COUNT) begin
        node_count <= cfg_data[NODE_BITS-1:0];
      end else if (cfg_index == REG_MAXIMIZE) begin
        maximize <= cfg_data[0];
      end
    end
  end

  // clamp node count to 1..NODES
  always_comb begin
    if (node_count == '0) begin
      eff = NODE_BITS'(1);
    end else if (32'(node_count) > NODES) begin
      eff = NODE_BITS'(NODES);
    end else begin
      eff = node_count;
    end
  end

  assign cfg.eff_nodes = eff;
  assign cfg.maximize  = maximize;

  // classify the beat
  always_comb begin
    q_item.e.u  = edge_in.edge_u;
    q_item.e.v  = edge_in.edge_v;
    q_item.e.w  = edge_in.edge_weight;
    q_item.last = edge_in.edge_last;
    q_item.ok   = (edge_in.edge_u != '0) && (edge_in.edge_u <= eff) &&
                  (edge_in.edge_v != '0) && (edge_in.edge_v <= eff);
  end

  assign q_push = push && !q_full;

endmodule

@@ sv/kst_back.sv @@
// ----------------------------------------------------------------------------
// kst_back
// Edge store, ordered selection scan and union-find merge of one edge set.
// ----------------------------------------------------------------------------
module kst_back import kst_pkg::*; #(
  parameter int NODES     = NODES_DEF,
  parameter int MAX_EDGES = MAX_EDGES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      q_empty,
  input  q_item_t   q_item,
  output logic      q_pop,
  input  logic      o_full,
  output logic      o_push,
  output tree_out_t o_item
);
  localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int NW = $clog2(NODES + 1);
  localparam int LG = $clog2(NODES);
  localparam int RW = (LG > 0) ? $clog2(LG + 1) : 1;
  localparam int KW = WEIGHT_BITS + EW;

  typedef struct packed {
    logic [RW-1:0] rank;
    logic [NW-1:0] parent;
  } uf_ent_t;

  back_state_t state, state_next;

  // stores
  edge_rec_t emem [MAX_EDGES];
  edge_rec_t em_rdata;
  uf_ent_t   ufmem [NODES + 1];
  uf_ent_t   uf_rdata;

  // set bookkeeping
  logic [EW:0]          ecnt;
  logic                 drop;
  logic [NW-1:0]        clr;
  logic [NODE_BITS-1:0] tree_cnt;

  // scan
  logic [EW:0]   scan_idx;
  logic          rd_pend;
  logic [EW-1:0] rd_idx;
  logic          best_valid;
  logic [KW-1:0] best_key;
  edge_rec_t     best;
  logic          prev_valid;
  logic [KW-1:0] prev_key;
  logic [KW-1:0] cand_key;
  logic          cand_better;

  // find and link
  logic [NW-1:0] cur;
  logic [NW-1:0] root_a;
  logic [RW-1:0] rank_a;
  logic [NW-1:0] root_b;
  logic [RW-1:0] rank_b;
  logic [NW-1:0] big_root;
  logic [RW-1:0] big_rank;

  // held tree edge
  logic      pend_valid;
  edge_rec_t pend;

  // control outputs
  logic          em_we;
  logic          issue;
  logic          uf_we;
  logic [NW-1:0] uf_waddr;
  uf_ent_t       uf_wdata;
  logic          stop;
  logic          scan_done;
  logic          store_ok;

  assign stop      = (tree_cnt == cfg.eff_nodes - NODE_BITS'(1));
  assign scan_done = (scan_idx == ecnt) && !rd_pend;
  assign store_ok  = q_item.ok && (ecnt < (EW+1)'(MAX_EDGES));
  assign cand_key  = {weight_key(em_rdata.w, cfg.maximize), rd_idx};
  assign cand_better = rd_pend && (!prev_valid || cand_key > prev_key) &&
                       (!best_valid || cand_key < best_key);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_LOAD: begin
        if (!q_empty && q_item.last) state_next = B_CLEAR;
      end
      B_CLEAR: begin
        if (clr == NW'(NODES)) state_next = B_SCAN;
      end
      B_SCAN: begin
        if (stop) state_next = B_FINAL;
        else if (scan_done) state_next = best_valid ? B_FINDU_REQ : B_FINAL;
      end
      B_FINDU_REQ: state_next = B_FINDU_CHK;
      B_FINDU_CHK: state_next = (uf_rdata.parent == cur) ? B_FINDV_REQ : B_FINDU_REQ;
      B_FINDV_REQ: state_next = B_FINDV_CHK;
      B_FINDV_CHK: state_next = (uf_rdata.parent == cur) ? B_LINK : B_FINDV_REQ;
      B_LINK: begin
        if (root_a == root_b) state_next = B_SCAN;
        else if (rank_a == rank_b) state_next = B_BUMP;
        else state_next = B_EMIT;
      end
      B_BUMP: state_next = B_EMIT;
      B_EMIT: begin
        if (!(pend_valid && o_full)) state_next = B_SCAN;
      end
      B_FINAL: begin
        if (!o_full) state_next = B_LOAD;
      end
      default: state_next = B_LOAD;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop    = 1'b0;
    em_we    = 1'b0;
    issue    = 1'b0;
    uf_we    = 1'b0;
    uf_waddr = clr;
    uf_wdata = '{rank: '0, parent: clr};
    o_push   = 1'b0;
    o_item   = '0;
    unique case (state)
      B_LOAD: begin
        q_pop = !q_empty;
        em_we = !q_empty && store_ok;
      end
      B_CLEAR: uf_we = 1'b1;
      B_SCAN: issue = !stop && (scan_idx != ecnt);
      B_LINK: begin
        if (root_a != root_b) begin
          uf_we = 1'b1;
          if (rank_a < rank_b) begin
            uf_waddr = root_a;
            uf_wdata = '{rank: rank_a, parent: root_b};
          end else begin
            uf_waddr = root_b;
            uf_wdata = '{rank: rank_b, parent: root_a};
          end
        end
      end
      B_BUMP: begin
        uf_we    = 1'b1;
        uf_waddr = big_root;
        uf_wdata = '{rank: big_rank + 1'b1, parent: big_root};
      end
      B_EMIT: begin
        o_push = pend_valid && !o_full;
        o_item = '{tree_u: pend.u, tree_v: pend.v, tree_weight: pend.w,
                   edge_valid: 1'b1, result_last: 1'b0, edges_dropped: drop};
      end
      B_FINAL: begin
        o_push = !o_full;
        if (pend_valid) begin
          o_item = '{tree_u: pend.u, tree_v: pend.v, tree_weight: pend.w,
                     edge_valid: 1'b1, result_last: 1'b1, edges_dropped: drop};
        end else begin
          o_item = '{tree_u: '0, tree_v: '0, tree_weight: '0,
                     edge_valid: 1'b0, result_last: 1'b1, edges_dropped: drop};
        end
      end
      default: ;
    endcase
  end

  // edge store, registered read
  always_ff @(posedge clk) begin
    if (em_we) begin
      emem[ecnt[EW-1:0]] <= q_item.e;
    end
    if (issue) begin
      em_rdata <= emem[scan_idx[EW-1:0]];
    end
  end

  // parent and rank store, registered read
  always_ff @(posedge clk) begin
    if (uf_we) begin
      ufmem[uf_waddr] <= uf_wdata;
    end
    uf_rdata <= ufmem[cur];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_LOAD;
      ecnt       <= '0;
      drop       <= 1'b0;
      clr        <= '0;
      tree_cnt   <= '0;
      scan_idx   <= '0;
      rd_pend    <= 1'b0;
      best_valid <= 1'b0;
      prev_valid <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= issue;
      unique case (state)
        B_LOAD: begin
          if (!q_empty) begin
            if (store_ok) ecnt <= ecnt + 1'b1;
            else drop <= 1'b1;
            if (q_item.last) begin
              clr        <= '0;
              tree_cnt   <= '0;
              scan_idx   <= '0;
              best_valid <= 1'b0;
              prev_valid <= 1'b0;
              pend_valid <= 1'b0;
            end
          end
        end
        B_CLEAR: clr <= clr + 1'b1;
        B_SCAN: begin
          if (issue) scan_idx <= scan_idx + 1'b1;
          if (cand_better) best_valid <= 1'b1;
          if (!stop && scan_done && best_valid) prev_valid <= 1'b1;
        end
        B_LINK: begin
          if (root_a == root_b) begin
            scan_idx   <= '0;
            best_valid <= 1'b0;
          end
        end
        B_EMIT: begin
          if (!(pend_valid && o_full)) begin
            pend_valid <= 1'b1;
            tree_cnt   <= tree_cnt + 1'b1;
            scan_idx   <= '0;
            best_valid <= 1'b0;
          end
        end
        B_FINAL: begin
          if (!o_full) begin
            ecnt <= '0;
            drop <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rd_pend) rd_idx <= rd_idx;
    if (issue) rd_idx <= scan_idx[EW-1:0];
    if (state == B_SCAN && cand_better) begin
      best_key <= cand_key;
      best     <= em_rdata;
    end
    if (state == B_SCAN && scan_done) begin
      prev_key <= best_key;
      cur      <= NW'(best.u);
    end
    if (state == B_FINDU_CHK) begin
      if (uf_rdata.parent == cur) begin
        root_a <= cur;
        rank_a <= uf_rdata.rank;
        cur    <= NW'(best.v);
      end else begin
        cur <= uf_rdata.parent;
      end
    end
    if (state == B_FINDV_CHK) begin
      if (uf_rdata.parent == cur) begin
        root_b <= cur;
        rank_b <= uf_rdata.rank;
      end else begin
        cur <= uf_rdata.parent;
      end
    end
    if (state == B_LINK) begin
      big_root <= (rank_a < rank_b) ? root_b : root_a;
      big_rank <= (rank_a < rank_b) ? rank_b : rank_a;
    end
    if (state == B_EMIT && !(pend_valid && o_full)) begin
      pend <= best;
    end
  end

  // edge count stays within the store
  a_ecnt_bound: assert property (@(posedge clk) disable iff (rst)
    ecnt <= (EW+1)'(MAX_EDGES))
    else $error("edge count past store depth");

  // tree never outgrows node count minus one during the work
  a_tree_bound: assert property (@(posedge clk) disable iff (rst)
    state != B_LOAD |-> tree_cnt <= cfg.eff_nodes - NODE_BITS'(1))
    else $error("too many tree edges");

  // result queue is never pushed while full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    o_push |-> !o_full)
    else $error("result pushed into full queue");

  // front queue drained only while loading
  a_pop_load: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == B_LOAD)
    else $error("edge popped outside load");

  // a final result returns the block to loading with an empty store
  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    (state == B_FINAL && !o_full) |=> (state == B_LOAD && ecnt == '0 && !drop))
    else $error("set not closed after final result");

endmodule

@@ sv/kruskal_spanning_tree.sv @@
// ----------------------------------------------------------------------------
// kruskal_spanning_tree
// Minimum or maximum spanning tree of a loaded weighted edge set.
// ----------------------------------------------------------------------------
// Edges enter through a queue-style port (push/full) one beat per cycle while
// full is low; a beat with edge_last closes the set. Endpoints outside 1 up to
// node_count clamped to 1..NODES and beats past MAX_EDGES are dropped and
// flagged in edges_dropped. Results leave through a queue-style port
// (empty/pop): one beat per tree edge in weight order (equal weights in
// arrival order), result_last on the final one; a set with no tree edge
// gives one beat with edge_valid 0. Loading takes one edge per cycle into a
// four-entry queue while the back end is loading. After the last edge the
// back end resets the parent/rank store, then per candidate edge scans the
// edge memory through one read port, walks the parent chain of each
// endpoint with a request and a check state per step, and links the roots.
// Edges of the next set queue up meanwhile until the front queue fills.
// Reset empties both queues and the edge store and restores node_count 32
// and minimize mode. A stalled receiver fills the result queue and the
// back end waits; no beat is lost. Config writes are taken at any cycle.
// ----------------------------------------------------------------------------
module kruskal_spanning_tree import kst_pkg::*; #(
  parameter int NODES     = NODES_DEF,
  parameter int MAX_EDGES = MAX_EDGES_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     push,
  output logic                     full,
  input  edge_in_t                 edge_in,
  output logic                     empty,
  input  logic                     pop,
  output tree_out_t                tree_out
);
  localparam int QW = $bits(q_item_t);
  localparam int OW = $bits(tree_out_t);

  cfg_t            cfg;
  logic            q_push;
  q_item_t         q_witem;
  q_item_t         q_ritem;
  logic [QW-1:0]   q_rbits;
  logic            q_empty;
  logic            q_pop;
  logic            o_full;
  logic            o_push;
  tree_out_t       o_item;
  logic [OW-1:0]   o_rbits;

  // front end: config and classification
  kst_front #(.NODES(NODES)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .edge_in   (edge_in),
    .q_push    (q_push),
    .q_item    (q_witem),
    .q_full    (full),
    .cfg       (cfg)
  );

  // queue between front and back
  kst_fifo #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_edge_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_push),
    .wdata (q_witem),
    .full  (full),
    .rd    (q_pop),
    .rdata (q_rbits),
    .empty (q_empty)
  );
  assign q_ritem = q_item_t'(q_rbits);

  // back end: store, scan, union-find
  kst_back #(.NODES(NODES), .MAX_EDGES(MAX_EDGES)) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_item  (q_ritem),
    .q_pop   (q_pop),
    .o_full  (o_full),
    .o_push  (o_push),
    .o_item  (o_item)
  );

  // result queue
  kst_fifo #(.WIDTH(OW), .DEPTH(QUEUE_DEPTH)) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (o_push),
    .wdata (o_item),
    .full  (o_full),
    .rd    (pop),
    .rdata (o_rbits),
    .empty (empty)
  );
  assign tree_out = tree_out_t'(o_rbits);

endmodule

@@ tb/sv/kruskal_spanning_tree_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kruskal_spanning_tree_tb
// Self-checking bench for the spanning tree block: edge sets go in, and every
// tree edge that comes out is checked against a predicted Kruskal run.
// ----------------------------------------------------------------------------
module kruskal_spanning_tree_tb;
  import kst_pkg::*;

  localparam int NODES     = NODES_DEF;
  localparam int MAX_EDGES = MAX_EDGES_DEF;
  localparam int LIMIT     = 2000000;

  // tree predictor and store of expected tree edges
  class tree_board;
    tree_out_t                     tree_q[$];
    logic [NODE_BITS-1:0]          eu[MAX_EDGES];
    logic [NODE_BITS-1:0]          ev[MAX_EDGES];
    logic signed [WEIGHT_BITS-1:0] ew[MAX_EDGES];
    int  n_stored;
    bit  dropped;
    int  node_cfg;
    bit  max_mode;
    int  errors;
    int  par[NODES+1];
    int  rnk[NODES+1];

    function new();
      n_stored = 0;
      dropped  = 0;
      node_cfg = 32;
      max_mode = 0;
      errors   = 0;
    endfunction

    function int eff_nodes();
      if (node_cfg == 0) return 1;
      if (node_cfg > NODES) return NODES;
      return node_cfg;
    endfunction

    function int find_root(int x);
      int r;
      int nx;
      r = x;
      while (par[r] != r) r = par[r];
      while (par[x] != r) begin
        nx = par[x];
        par[x] = r;
        x = nx;
      end
      return r;
    endfunction

    // note one accepted edge beat; a closing beat runs the whole set
    function void note_edge(edge_in_t e);
      int n;
      int ord[MAX_EDGES];
      int cur;
      int j;
      int ra;
      int rb;
      int tmp;
      int emitted;
      bit better;
      tree_out_t t;
      n = eff_nodes();
      if (e.edge_u < 1 || e.edge_u > n || e.edge_v < 1 || e.edge_v > n ||
          n_stored >= MAX_EDGES) begin
        dropped = 1;
      end else begin
        eu[n_stored] = e.edge_u;
        ev[n_stored] = e.edge_v;
        ew[n_stored] = e.edge_weight;
        n_stored++;
      end
      if (!e.edge_last) return;
      // stable insertion sort by weight
      for (int i = 0; i < n_stored; i++) begin
        cur = i;
        j = i;
        while (j > 0) begin
          better = max_mode ? (ew[cur] > ew[ord[j-1]]) : (ew[cur] < ew[ord[j-1]]);
          if (!better) break;
          ord[j] = ord[j-1];
          j--;
        end
        ord[j] = cur;
      end
      for (int i = 0; i <= NODES; i++) begin
        par[i] = i;
        rnk[i] = 0;
      end
      emitted = 0;
      for (int i = 0; i < n_stored && emitted < n - 1; i++) begin
        ra = find_root(eu[ord[i]]);
        rb = find_root(ev[ord[i]]);
        if (ra != rb) begin
          if (rnk[ra] < rnk[rb]) begin
            tmp = ra; ra = rb; rb = tmp;
          end
          par[rb] = ra;
          if (rnk[ra] == rnk[rb]) rnk[ra]++;
          t.tree_u        = eu[ord[i]];
          t.tree_v        = ev[ord[i]];
          t.tree_weight   = ew[ord[i]];
          t.edge_valid    = 1'b1;
          t.result_last   = 1'b0;
          t.edges_dropped = dropped;
          tree_q = {tree_q, t};
          emitted++;
        end
      end
      if (emitted == 0) begin
        t = '0;
        t.result_last   = 1'b1;
        t.edges_dropped = dropped;
        tree_q = {tree_q, t};
      end else begin
        tree_q[tree_q.size()-1].result_last = 1'b1;
      end
      n_stored = 0;
      dropped  = 0;
    endfunction

    // compare one popped beat with the oldest expected tree edge
    function void check(tree_out_t a);
      tree_out_t x;
      if (tree_q.size() == 0) begin
        $error("unexpected result beat u=%0d v=%0d w=%0d", a.tree_u, a.tree_v,
               a.tree_weight);
        errors++;
        return;
      end
      x = tree_q.pop_front();
      if (a.tree_u !== x.tree_u) begin
        $error("tree_u expected %0d actual %0d", x.tree_u, a.tree_u); errors++;
      end
      if (a.tree_v !== x.tree_v) begin
        $error("tree_v expected %0d actual %0d", x.tree_v, a.tree_v); errors++;
      end
      if (a.tree_weight !== x.tree_weight) begin
        $error("tree_weight expected %0d actual %0d", x.tree_weight, a.tree_weight);
        errors++;
      end
      if (a.edge_valid !== x.edge_valid) begin
        $error("edge_valid expected %0d actual %0d", x.edge_valid, a.edge_valid);
        errors++;
      end
      if (a.result_last !== x.result_last) begin
        $error("result_last expected %0d actual %0d", x.result_last, a.result_last);
        errors++;
      end
      if (a.edges_dropped !== x.edges_dropped) begin
        $error("edges_dropped expected %0d actual %0d", x.edges_dropped,
               a.edges_dropped);
        errors++;
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  logic                     push;
  logic                     full;
  edge_in_t                 edge_in;
  logic                     empty;
  logic                     pop;
  tree_out_t                tree_out;

  tree_board board;
  bit        quiet;
  bit        long_hold;
  int        cycles;
  int        sent;

  kruskal_spanning_tree uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .edge_in   (edge_in),
    .empty     (empty),
    .pop       (pop),
    .tree_out  (tree_out)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("kruskal_spanning_tree_tb: FAIL");
      $finish;
    end
  end

  // result beat check
  always @(posedge clk) begin
    if (!rst && pop && !empty) board.check(tree_out);
  end

  // receiver: random stall bursts, one long hold-off, none at the end
  initial begin
    int len;
    pop <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold) begin
        pop <= 1'b0;
        repeat (3000) @(posedge clk);
        long_hold = 0;
      end else if (quiet || $urandom_range(0, 2) != 0) begin
        pop <= 1'b1;
        @(posedge clk);
      end else begin
        len = $urandom_range(1, 14);
        pop <= 1'b0;
        repeat (len) @(posedge clk);
      end
    end
  end

  // one edge beat, held until taken
  task automatic send_edge(input int u, input int v, input int w, input bit last);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    push                <= 1'b1;
    edge_in.edge_u      <= u[NODE_BITS-1:0];
    edge_in.edge_v      <= v[NODE_BITS-1:0];
    edge_in.edge_weight <= w[WEIGHT_BITS-1:0];
    edge_in.edge_last   <= last;
    @(posedge clk);
    while (full) @(posedge clk);
    board.note_edge(edge_in);
    sent++;
  endtask

  // wait until every expected tree edge is out and the back end settles
  task automatic drain();
    push <= 1'b0;
    while (board.tree_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_BITS-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_NODE_COUNT) board.node_cfg = val;
    else board.max_mode = val[0];
    @(posedge clk);
  endtask

  // random set: mostly well-formed edges with tie-prone weights, some noise
  task automatic random_set(input int size);
    int n;
    int u;
    int v;
    int w;
    n = board.eff_nodes();
    for (int i = 0; i < size; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        u = $urandom_range(0, 63);
        v = $urandom_range(0, 63);
      end else begin
        u = $urandom_range(1, n);
        v = $urandom_range(1, n);
      end
      w = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 65535) : $urandom_range(0, 5);
      send_edge(u, v, w, i == size - 1);
    end
  endtask

  task automatic random_phase(input int items);
    int target;
    int size;
    target = sent + items;
    while (sent < target) begin
      size = ($urandom_range(0, 14) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 10);
      if (size > target - sent) size = target - sent;
      random_set(size);
    end
  endtask

  initial begin
    board     = new();
    quiet     = 0;
    long_hold = 0;
    sent      = 0;
    rst       <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= REG_NODE_COUNT;
    cfg_data  <= '0;
    push      <= 1'b0;
    edge_in   <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes of weight, ties, self loop, bad endpoints
    write_reg(REG_NODE_COUNT, 32);
    write_reg(REG_MAXIMIZE, 0);
    send_edge(1, 32, 32767, 0);
    send_edge(32, 2, -32768, 0);
    send_edge(2, 3, 7, 0);
    send_edge(3, 1, 7, 0);
    send_edge(5, 5, -5, 0);
    send_edge(0, 4, 1, 0);
    send_edge(4, 33, 1, 0);
    send_edge(63, 63, 1, 0);
    send_edge(4, 1, 0, 1);
    // lone self loop gives the empty tree
    send_edge(9, 9, 3, 1);
    // dropped closing edge still starts the work
    send_edge(6, 7, -1, 0);
    send_edge(0, 7, 2, 1);
    drain();
    // maximize with out-of-range node count acting as the full node set
    write_reg(REG_MAXIMIZE, 1);
    write_reg(REG_NODE_COUNT, 63);
    send_edge(31, 32, -32768, 0);
    send_edge(32, 1, 32767, 0);
    send_edge(1, 31, 100, 0);
    send_edge(2, 1, 32767, 1);
    drain();
    // zero node count acts as one node: never any tree edge
    write_reg(REG_NODE_COUNT, 0);
    send_edge(1, 1, 5, 0);
    send_edge(1, 2, 5, 1);
    drain();
    // store overflow
    write_reg(REG_NODE_COUNT, 32);
    random_set(68);
    drain();

    // random phases over several settings; long receiver hold in the first
    long_hold = 1;
    random_phase(45);
    drain();
    write_reg(REG_NODE_COUNT, 5);
    write_reg(REG_MAXIMIZE, 0);
    random_phase(40);
    drain();
    write_reg(REG_NODE_COUNT, 1);
    random_phase(15);
    drain();
    write_reg(REG_NODE_COUNT, 17);
    write_reg(REG_MAXIMIZE, 1);
    random_phase(40);
    drain();
    write_reg(REG_NODE_COUNT, 2);
    write_reg(REG_MAXIMIZE, 0);
    random_phase(25);
    drain();
    write_reg(REG_NODE_COUNT, 32);
    random_phase(35);
    drain();
    quiet = 1;
    write_reg(REG_MAXIMIZE, 1);
    random_phase(24);
    drain();
    repeat (100) @(posedge clk);

    if (board.errors == 0) begin
      $display("kruskal_spanning_tree_tb: PASS");
    end else begin
      $display("kruskal_spanning_tree_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/kst_pkg.sv
sv/kst_fifo.sv
sv/kst_front.sv
sv/kst_back.sv
sv/kruskal_spanning_tree.sv
tb/sv/kruskal_spanning_tree_tb.sv
